// ----- sv/lspp_pkg.sv -----
// lspp_pkg: shared types and constants for the scanner measurement packet parser
// no dependencies; imported by every lspp module and the top level
`timescale 1ns / 1ps

package lspp_pkg;

   // packet geometry
   localparam int PACKET_BYTES = 5;
   localparam int WIN_DEPTH    = PACKET_BYTES - 1;
   localparam int WIN_IDX_W    = $clog2(WIN_DEPTH);
   localparam int FILL_W       = $clog2(PACKET_BYTES);

   // field widths
   localparam int BYTE_W    = 8;
   localparam int QUALITY_W = 6;
   localparam int ANGLE_W   = 15;
   localparam int RANGE_W   = 16;
   localparam int COUNT_W   = 12;

   // reset value of the scan length limit
   localparam logic [COUNT_W-1:0] MAX_POINTS_RESET = COUNT_W'(2000);

   typedef logic [BYTE_W-1:0] byte_type;

   // one complete packet pulled out of the byte window
   typedef struct packed {
      logic     valid;
      byte_type b0;
      byte_type b1;
      byte_type b2;
      byte_type b3;
      byte_type b4;
   } packet_type;

   // one measurement item
   typedef struct packed {
      logic [QUALITY_W-1:0] quality;
      logic [ANGLE_W-1:0]   angle_q6;
      logic [RANGE_W-1:0]   range_q2;
      logic                 scan_start;
      logic [COUNT_W-1:0]   point_index;
      logic [COUNT_W-1:0]   closed_count;
   } result_type;

   // occupancy of the output buffer
   typedef struct packed {
      logic head_valid;
      logic skid_valid;
   } buf_status_type;

endpackage

// ----- sv/lidar_scan_packet_parser.sv -----
// lidar_scan_packet_parser: top level of the scanner measurement packet parser
// depends on lspp_pkg, lspp_window, lspp_scan, lspp_out_buf
`timescale 1ns / 1ps

// Usage
// - req channel: one received serial byte per item on req_rx_byte
// - rsp channel: one measurement item per recognized five-byte packet; bytes
//   that do not complete a packet give no item
// - csr port: csr_wr_en writes csr_wr_data into the scan length limit
//   (max_points); write only while the block is idle
// - timing: the input register holds the last byte of a packet while the
//   window and scan logic settle; the next edge loads the measurement into
//   the output buffer, whose head drives rsp
// - throughput: one byte per cycle while req_stall is low; the window test,
//   point counter update and field extraction are all combinational
// - stall: a two-entry output buffer absorbs results while rsp_stall is
//   high; req_stall rises only when the buffer plus the byte in flight
//   could fill it, so no item is lost
// - reset: synchronous; empties the window, clears the point count, sets
//   max_points to 2000 and drops any buffered items

module lidar_scan_packet_parser import lspp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [QUALITY_W-1:0] rsp_quality,
   output logic [ANGLE_W-1:0]   rsp_angle_q6,
   output logic [RANGE_W-1:0]   rsp_range_q2,
   output logic                 rsp_scan_start,
   output logic [COUNT_W-1:0]   rsp_point_index,
   output logic [COUNT_W-1:0]   rsp_closed_count,
   input  logic                 csr_wr_en,
   input  logic [COUNT_W-1:0]   csr_wr_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   byte_type           in_byte_ff;
   logic [COUNT_W-1:0] max_points_ff;
   packet_type         packet;
   logic               result_valid;
   result_type         result;
   result_type         out_data;
   logic               pop;
   buf_status_type     status;
   logic [1:0]         pending;

   // input stall: buffered items plus the byte in flight, less the one leaving
   assign pending   = 2'(status.head_valid) + 2'(status.skid_valid) + 2'(in_valid_ff)
                      - 2'(pop);
   assign req_stall = pending >= 2'd2;
   assign in_valid_in = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // scan length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_points_ff <= MAX_POINTS_RESET;
      end else if (csr_wr_en) begin
         max_points_ff <= csr_wr_data;
      end
   end

   lspp_window u_window (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .byte_data  (in_byte_ff),
      .packet     (packet)
   );

   lspp_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .packet       (packet),
      .max_points   (max_points_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   lspp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .pop       (pop),
      .status    (status)
   );

   // result ports
   assign rsp_quality      = out_data.quality;
   assign rsp_angle_q6     = out_data.angle_q6;
   assign rsp_range_q2     = out_data.range_q2;
   assign rsp_scan_start   = out_data.scan_start;
   assign rsp_point_index  = out_data.point_index;
   assign rsp_closed_count = out_data.closed_count;

`ifndef SYNTHESIS
   a_closed_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scan_start |-> rsp_closed_count == '0)
      else $error("closed count without scan start");

   a_start_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_start |-> rsp_point_index == '0)
      else $error("scan start with nonzero point index");
`endif

endmodule

// ----- sv/lspp_window.sv -----
// lspp_window: sliding byte window with packet sync test
// depends on lspp_pkg
`timescale 1ns / 1ps

module lspp_window import lspp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  byte_type   byte_data,
   output packet_type packet
);

   // the first WIN_DEPTH bytes are held; the last byte of a packet comes in live
   byte_type          win_ff [WIN_DEPTH];
   byte_type          win_in [WIN_DEPTH];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              sync_ok;

   // header test: byte 0 bit 0 differs from bit 1, byte 1 bit 0 set
   assign sync_ok = (win_ff[0][0] != win_ff[0][1]) && win_ff[1][0];

   // window update
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      packet  = '{valid: 1'b0, b0: win_ff[0], b1: win_ff[1], b2: win_ff[2],
                  b3: win_ff[3], b4: byte_data};
      if (byte_valid) begin
         if (fill_ff < FILL_W'(WIN_DEPTH)) begin
            win_in[fill_ff[WIN_IDX_W-1:0]] = byte_data;
            fill_in = fill_ff + FILL_W'(1);
         end else if (sync_ok) begin
            packet.valid = 1'b1;
            fill_in      = '0;
         end else begin
            // drop the oldest byte and keep the window full
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[WIN_DEPTH-1] = byte_data;
         end
      end
   end

   // fill counter
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // window bytes
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("window fill out of range");

   a_packet_empties: assert property (@(posedge clock) disable iff (reset)
      packet.valid |=> fill_ff == '0)
      else $error("window not emptied after packet");
`endif

endmodule

// ----- sv/lspp_scan.sv -----
// lspp_scan: scan bookkeeping and measurement field extraction
// depends on lspp_pkg
`timescale 1ns / 1ps

module lspp_scan import lspp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  packet_type         packet,
   input  logic [COUNT_W-1:0] max_points,
   output logic               result_valid,
   output result_type         result
);

   logic [COUNT_W-1:0] point_count_ff;
   logic [COUNT_W-1:0] point_count_in;
   logic [COUNT_W-1:0] base_index;
   logic               start;

   // new scan on the start bit or when the limit is reached
   assign start      = packet.b0[0] || (point_count_ff >= max_points);
   assign base_index = start ? '0 : point_count_ff;

   // measurement fields
   always_comb begin
      result_valid        = packet.valid;
      result.quality      = packet.b0[BYTE_W-1:2];
      result.angle_q6     = {packet.b2, packet.b1[BYTE_W-1:1]};
      result.range_q2     = {packet.b4, packet.b3};
      result.scan_start   = start;
      result.point_index  = base_index;
      result.closed_count = start ? point_count_ff : '0;
   end

   // point counter
   assign point_count_in = packet.valid ? base_index + COUNT_W'(1) : point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

endmodule

// ----- sv/lspp_out_buf.sv -----
// lspp_out_buf: two-entry output buffer (head register plus skid register)
// depends on lspp_pkg
`timescale 1ns / 1ps

module lspp_out_buf import lspp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  result_type     push_data,
   input  logic           out_stall,
   output logic           out_valid,
   output result_type     out_data,
   output logic           pop,
   output buf_status_type status
);

   logic       head_valid_ff;
   logic       head_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type head_ff;
   result_type head_in;
   result_type skid_ff;
   result_type skid_in;

   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign pop       = head_valid_ff && !out_stall;
   assign status    = '{head_valid: head_valid_ff, skid_valid: skid_valid_ff};

   // next buffer contents
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   // occupancy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && head_valid_ff && skid_valid_ff && !pop))
      else $error("output buffer overflow");

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without head entry");
`endif

endmodule
